### rtl/piqa_pkg.sv
package piqa_pkg;

  localparam int LEVELS_DEF   = 4;
  localparam int CAPACITY_DEF = 32;

  localparam int ID_W      = 16;
  localparam int PRI_W     = 3;
  localparam int TIME_W    = 32;
  localparam int KIND_W    = 3;
  localparam int THR_W     = 6;
  localparam int BOOST_W   = 3;
  localparam int CFG_IDX_W = 3;
  localparam int WAIT_REGS = 4;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_REMOVE  = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_BYPASS   = 3'd0,
    KIND_EARLY    = 3'd1,
    KIND_STARVED  = 3'd2,
    KIND_QUEUED   = 3'd3,
    KIND_REMOVED  = 3'd4,
    KIND_NOTFOUND = 3'd5,
    KIND_FULL     = 3'd6
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SKIP_SCHED   = 3'd0,
    REG_DISPATCH_THR = 3'd1,
    REG_BOOST_STEP   = 3'd2,
    REG_AGE_LIMIT0   = 3'd3,
    REG_AGE_LIMIT1   = 3'd4,
    REG_AGE_LIMIT2   = 3'd5,
    REG_AGE_LIMIT3   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic                              skip_sched;
    logic [THR_W-1:0]                  early_thr;
    logic [BOOST_W-1:0]                boost_step;
    logic [WAIT_REGS-1:0][TIME_W-1:0]  age_limit;
  } cfg_t;

  typedef enum logic [3:0] {
    CMD_IDLE,
    CMD_CHECK,
    CMD_SEARCH,
    CMD_REM_HEAD,
    CMD_PRED,
    CMD_DISP_CHECK,
    CMD_DISP,
    CMD_LVL_START,
    CMD_WALK,
    CMD_LVL_END,
    CMD_DONE
  } cmd_t;

  typedef struct packed {
    logic is_remove;
    logic check_done;
    logic search_hit;
    logic search_miss;
    logic head_hit;
    logic pred_hit;
    logic dispatch;
    logic lvl_empty;
    logic walk_end;
    logic last_lvl;
  } status_t;

endpackage

### rtl/priority_io_queue_with_aging.sv
// Channel   Ports                                                   Handshake
// --------  ------------------------------------------------------  --------------------------
// item in   operation, request_id, priority_req, now_ms             start & !busy
// result    request_id_res, result_kind, last                       result_valid, one cycle
// config    cfg_index, cfg_data                                     cfg_valid & cfg_ready
//
// Bypass and full cases end at the check. An enqueue that is queued also
// runs the dispatch check and an aging scan that visits the entries of
// each level in turn. An entry boosted one level at a time is visited again
// at each level it reaches, so the scan visits at most CAPACITY*LEVELS
// entries. A remove searches the slots for the id, unlinks it at once if it
// heads its level, and else passes each entry ahead of it while locating
// the predecessor.
// Reset: synchronous rst empties all queues and loads register defaults;
// no clearing pass. Results are strobed for one cycle; there is no stall.
module priority_io_queue_with_aging #(
  parameter int LEVELS   = piqa_pkg::LEVELS_DEF,
  parameter int CAPACITY = piqa_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            operation,
  input  logic [piqa_pkg::ID_W-1:0]       request_id,
  input  logic [piqa_pkg::PRI_W-1:0]      priority_req,
  input  logic [piqa_pkg::TIME_W-1:0]     now_ms,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [piqa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [piqa_pkg::TIME_W-1:0]     cfg_data,
  output logic                            result_valid,
  output logic [piqa_pkg::ID_W-1:0]       request_id_res,
  output logic [piqa_pkg::KIND_W-1:0]     result_kind,
  output logic                            last
);
  import piqa_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;
  logic    load;

  // transfer an item when start is high and the sequencer sits idle
  assign load = start & ~busy;

  piqa_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer: steps through check, search, dispatch and the aging walk
  piqa_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // slot memories, per-level linked lists and result register
  piqa_datapath #(
    .LEVELS   (LEVELS),
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .load           (load),
    .cmd            (cmd),
    .cfg            (cfg),
    .operation      (operation),
    .request_id     (request_id),
    .priority_req   (priority_req),
    .now_ms         (now_ms),
    .status         (status),
    .result_valid   (result_valid),
    .request_id_res (request_id_res),
    .result_kind    (result_kind),
    .last           (last)
  );

endmodule

### rtl/piqa_cfg.sv
module piqa_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [piqa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [piqa_pkg::TIME_W-1:0]     cfg_data,
  output piqa_pkg::cfg_t                  cfg
);
  import piqa_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.skip_sched   <= 1'b0;
      cfg.early_thr    <= THR_W'(16);
      cfg.boost_step   <= BOOST_W'(1);
      cfg.age_limit[0] <= TIME_W'(1000);
      cfg.age_limit[1] <= TIME_W'(500);
      cfg.age_limit[2] <= TIME_W'(250);
      cfg.age_limit[3] <= TIME_W'(100);
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_SKIP_SCHED:   cfg.skip_sched   <= cfg_data[0];
        REG_DISPATCH_THR: cfg.early_thr    <= cfg_data[THR_W-1:0];
        REG_BOOST_STEP:   cfg.boost_step   <= cfg_data[BOOST_W-1:0];
        REG_AGE_LIMIT0:   cfg.age_limit[0] <= cfg_data;
        REG_AGE_LIMIT1:   cfg.age_limit[1] <= cfg_data;
        REG_AGE_LIMIT2:   cfg.age_limit[2] <= cfg_data;
        REG_AGE_LIMIT3:   cfg.age_limit[3] <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### rtl/piqa_ctrl.sv
module piqa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  piqa_pkg::status_t  status,
  output piqa_pkg::cmd_t     cmd,
  output logic               busy
);
  import piqa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SEARCH, S_REM_HEAD, S_PRED, S_DISP_CHECK, S_DISP,
    S_LVL_START, S_WALK, S_LVL_END, S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:       if (start) state_next = S_CHECK;
      S_CHECK: begin
        if (status.is_remove)       state_next = S_SEARCH;
        else if (status.check_done) state_next = S_IDLE;
        else                        state_next = S_DISP_CHECK;
      end
      S_SEARCH: begin
        if (status.search_hit)       state_next = S_REM_HEAD;
        else if (status.search_miss) state_next = S_IDLE;
      end
      S_REM_HEAD:   state_next = status.head_hit ? S_IDLE : S_PRED;
      S_PRED:       if (status.pred_hit) state_next = S_IDLE;
      S_DISP_CHECK: state_next = status.dispatch ? S_DISP : S_LVL_START;
      S_DISP:       state_next = S_LVL_START;
      S_LVL_START: begin
        if (!status.lvl_empty)    state_next = S_WALK;
        else if (status.last_lvl) state_next = S_DONE;
      end
      S_WALK:       if (status.walk_end) state_next = S_LVL_END;
      S_LVL_END:    state_next = status.last_lvl ? S_DONE : S_LVL_START;
      S_DONE:       state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    case (state)
      S_IDLE:       cmd = CMD_IDLE;
      S_CHECK:      cmd = CMD_CHECK;
      S_SEARCH:     cmd = CMD_SEARCH;
      S_REM_HEAD:   cmd = CMD_REM_HEAD;
      S_PRED:       cmd = CMD_PRED;
      S_DISP_CHECK: cmd = CMD_DISP_CHECK;
      S_DISP:       cmd = CMD_DISP;
      S_LVL_START:  cmd = CMD_LVL_START;
      S_WALK:       cmd = CMD_WALK;
      S_LVL_END:    cmd = CMD_LVL_END;
      S_DONE:       cmd = CMD_DONE;
      default:      cmd = CMD_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

### rtl/piqa_datapath.sv
module piqa_datapath #(
  parameter int LEVELS   = piqa_pkg::LEVELS_DEF,
  parameter int CAPACITY = piqa_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  piqa_pkg::cmd_t                cmd,
  input  piqa_pkg::cfg_t                cfg,
  input  logic                          operation,
  input  logic [piqa_pkg::ID_W-1:0]     request_id,
  input  logic [piqa_pkg::PRI_W-1:0]    priority_req,
  input  logic [piqa_pkg::TIME_W-1:0]   now_ms,
  output piqa_pkg::status_t             status,
  output logic                          result_valid,
  output logic [piqa_pkg::ID_W-1:0]     request_id_res,
  output logic [piqa_pkg::KIND_W-1:0]   result_kind,
  output logic                          last
);
  import piqa_pkg::*;

  localparam int SW = $clog2(CAPACITY);
  localparam int LW = $clog2(LEVELS);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int NW = ((LW > BOOST_W) ? LW : BOOST_W) + 1;

  // captured item
  logic              op_q;
  logic [ID_W-1:0]   id_q;
  logic [PRI_W-1:0]  pri_q;
  logic [TIME_W-1:0] now_q;

  // slot store
  logic [ID_W-1:0]   mem_req   [CAPACITY];
  logic [TIME_W-1:0] mem_stamp [CAPACITY];
  logic [LW-1:0]     mem_lvl   [CAPACITY];
  logic [SW-1:0]     mem_next  [CAPACITY];
  logic [ID_W-1:0]   rd_req;
  logic [TIME_W-1:0] rd_stamp;
  logic [LW-1:0]     rd_lvl;
  logic [SW-1:0]     rd_next;

  logic [CAPACITY-1:0] slot_valid, slot_valid_next;
  logic [LEVELS-1:0]   level_nonempty, level_nonempty_next;
  logic [SW-1:0]       level_head [LEVELS];
  logic [SW-1:0]       level_tail [LEVELS];
  logic [CW-1:0]       queued_count, queued_count_next;

  // walk and search registers
  logic [SW:0]   idx, idx_next;
  logic          pend, pend_next;
  logic [SW-1:0] srch_slot, srch_slot_next;
  logic [SW-1:0] cur, cur_next_slot;
  logic [LW-1:0] cur_lvl, cur_lvl_next;
  logic [SW-1:0] rem_next, rem_next_next;
  logic [SW-1:0] cur_tail, cur_tail_next;
  logic [SW-1:0] walk_addr, walk_addr_next;
  logic          kept_any, kept_any_next;
  logic [SW-1:0] first_kept, first_kept_next;
  logic [SW-1:0] last_kept, last_kept_next;

  // memory port controls
  logic          rd_en;
  logic [SW-1:0] rd_addr;
  logic          req_we, stamp_we, lvl_we, nx_we;
  logic [SW-1:0] mw_slot, nx_addr, nx_wd;
  logic [LW-1:0] lvl_wd;

  // level table port
  logic [LW-1:0] la;
  logic          head_we, tail_we, ne_set, ne_clr;
  logic [SW-1:0] head_wd, tail_wd;

  logic              emit, emit_last;
  logic [ID_W-1:0]   emit_id;
  kind_t             emit_kind;

  logic          free_found;
  logic [SW-1:0] free_slot;
  logic [LW-1:0] first_ne;
  logic [TIME_W-1:0] limit;
  logic          starved, mv, urgent_mv;
  logic [NW-1:0] nl_sum, nl;
  logic          hit, last_lvl;

  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_found = 1'b1;
        free_slot  = SW'(i);
      end
    end
    first_ne = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (level_nonempty[i]) first_ne = LW'(i);
    end
    limit = cfg.age_limit[WAIT_REGS-1];
    for (int i = 0; i < WAIT_REGS; i++) begin
      if (int'(cur_lvl) == i) limit = cfg.age_limit[i];
    end
  end

  assign starved   = {1'b0, now_q} > ({1'b0, rd_stamp} + {1'b0, limit});
  assign nl_sum    = NW'(cur_lvl) + NW'(cfg.boost_step);
  assign nl        = (nl_sum > NW'(LEVELS)) ? NW'(LEVELS) : nl_sum;
  assign mv        = starved && (cfg.boost_step != '0);
  assign urgent_mv = mv && (nl == NW'(LEVELS));
  assign hit       = pend && slot_valid[srch_slot] && (rd_req == id_q);
  assign last_lvl  = (cur_lvl == LW'(LEVELS - 1));

  always_comb begin
    slot_valid_next     = slot_valid;
    level_nonempty_next = level_nonempty;
    queued_count_next   = queued_count;
    idx_next            = idx;
    pend_next           = pend;
    srch_slot_next      = srch_slot;
    cur_next_slot       = cur;
    cur_lvl_next        = cur_lvl;
    rem_next_next       = rem_next;
    cur_tail_next       = cur_tail;
    walk_addr_next      = walk_addr;
    kept_any_next       = kept_any;
    first_kept_next     = first_kept;
    last_kept_next      = last_kept;
    rd_en    = 1'b0;
    rd_addr  = '0;
    req_we   = 1'b0;
    stamp_we = 1'b0;
    lvl_we   = 1'b0;
    nx_we    = 1'b0;
    mw_slot  = free_slot;
    nx_addr  = '0;
    nx_wd    = '0;
    lvl_wd   = pri_q[LW-1:0];
    la       = cur_lvl;
    head_we  = 1'b0;
    tail_we  = 1'b0;
    head_wd  = '0;
    tail_wd  = '0;
    ne_set   = 1'b0;
    ne_clr   = 1'b0;
    emit      = 1'b0;
    emit_last = 1'b1;
    emit_id   = id_q;
    emit_kind = KIND_QUEUED;
    status    = '0;
    status.last_lvl = last_lvl;

    case (cmd)
      CMD_CHECK: begin
        if (op_q == OP_REMOVE) begin
          status.is_remove = 1'b1;
          idx_next  = '0;
          pend_next = 1'b0;
        end else if (cfg.skip_sched || int'(pri_q) >= LEVELS) begin
          status.check_done = 1'b1;
          emit      = 1'b1;
          emit_kind = KIND_BYPASS;
        end else if (!free_found) begin
          status.check_done = 1'b1;
          emit      = 1'b1;
          emit_kind = KIND_FULL;
        end else begin
          // append to the tail of the requested level
          la       = pri_q[LW-1:0];
          req_we   = 1'b1;
          stamp_we = 1'b1;
          lvl_we   = 1'b1;
          if (level_nonempty[la]) begin
            nx_we   = 1'b1;
            nx_addr = level_tail[la];
            nx_wd   = free_slot;
          end else begin
            head_we = 1'b1;
            head_wd = free_slot;
            ne_set  = 1'b1;
          end
          tail_we = 1'b1;
          tail_wd = free_slot;
          slot_valid_next[free_slot] = 1'b1;
          queued_count_next = queued_count + CW'(1);
        end
      end
      CMD_SEARCH: begin
        status.search_hit  = hit;
        status.search_miss = pend && !hit && (srch_slot == SW'(CAPACITY - 1));
        if (status.search_miss) begin
          emit      = 1'b1;
          emit_kind = KIND_NOTFOUND;
        end else if (!hit && (int'(idx) < CAPACITY)) begin
          rd_en          = 1'b1;
          rd_addr        = idx[SW-1:0];
          srch_slot_next = idx[SW-1:0];
          pend_next      = 1'b1;
          idx_next       = idx + (SW+1)'(1);
        end
      end
      CMD_REM_HEAD: begin
        la = rd_lvl;
        if (level_head[la] == srch_slot) begin
          status.head_hit = 1'b1;
          if (level_tail[la] == srch_slot) begin
            ne_clr = 1'b1;
          end else begin
            head_we = 1'b1;
            head_wd = rd_next;
          end
          slot_valid_next[srch_slot] = 1'b0;
          queued_count_next = queued_count - CW'(1);
          emit      = 1'b1;
          emit_kind = KIND_REMOVED;
        end else begin
          // hunt for the predecessor from the head
          rem_next_next  = rd_next;
          cur_lvl_next   = rd_lvl;
          rd_en          = 1'b1;
          rd_addr        = level_head[la];
          walk_addr_next = level_head[la];
        end
      end
      CMD_PRED: begin
        if (rd_next == srch_slot) begin
          status.pred_hit = 1'b1;
          nx_we   = 1'b1;
          nx_addr = walk_addr;
          nx_wd   = rem_next;
          if (level_tail[la] == srch_slot) begin
            tail_we = 1'b1;
            tail_wd = walk_addr;
          end
          slot_valid_next[srch_slot] = 1'b0;
          queued_count_next = queued_count - CW'(1);
          emit      = 1'b1;
          emit_kind = KIND_REMOVED;
        end else begin
          rd_en          = 1'b1;
          rd_addr        = rd_next;
          walk_addr_next = rd_next;
        end
      end
      CMD_DISP_CHECK: begin
        la = first_ne;
        if (int'(queued_count) > int'(cfg.early_thr)) begin
          status.dispatch = 1'b1;
          cur_lvl_next  = first_ne;
          cur_next_slot = level_head[la];
          rd_en         = 1'b1;
          rd_addr       = level_head[la];
        end else begin
          cur_lvl_next = '0;
        end
      end
      CMD_DISP: begin
        if (level_tail[la] == cur) begin
          ne_clr = 1'b1;
        end else begin
          head_we = 1'b1;
          head_wd = rd_next;
        end
        slot_valid_next[cur] = 1'b0;
        queued_count_next = queued_count - CW'(1);
        emit      = 1'b1;
        emit_last = 1'b0;
        emit_id   = rd_req;
        emit_kind = KIND_EARLY;
        cur_lvl_next = '0;
      end
      CMD_LVL_START: begin
        if (level_nonempty[la]) begin
          rd_en          = 1'b1;
          rd_addr        = level_head[la];
          walk_addr_next = level_head[la];
          cur_tail_next  = level_tail[la];
          kept_any_next  = 1'b0;
        end else begin
          status.lvl_empty = 1'b1;
          if (!last_lvl) cur_lvl_next = cur_lvl + LW'(1);
        end
      end
      CMD_WALK: begin
        mw_slot = walk_addr;
        if (!mv) begin
          // keep: rebuild this level's chain from the survivors
          if (kept_any) begin
            nx_we   = 1'b1;
            nx_addr = last_kept;
            nx_wd   = walk_addr;
          end else begin
            first_kept_next = walk_addr;
          end
          last_kept_next = walk_addr;
          kept_any_next  = 1'b1;
        end else if (urgent_mv) begin
          slot_valid_next[walk_addr] = 1'b0;
          queued_count_next = queued_count - CW'(1);
          emit      = 1'b1;
          emit_last = 1'b0;
          emit_id   = rd_req;
          emit_kind = KIND_STARVED;
        end else begin
          la       = nl[LW-1:0];
          stamp_we = 1'b1;
          lvl_we   = 1'b1;
          lvl_wd   = nl[LW-1:0];
          if (level_nonempty[la]) begin
            nx_we   = 1'b1;
            nx_addr = level_tail[la];
            nx_wd   = walk_addr;
          end else begin
            head_we = 1'b1;
            head_wd = walk_addr;
            ne_set  = 1'b1;
          end
          tail_we = 1'b1;
          tail_wd = walk_addr;
        end
        if (walk_addr == cur_tail) begin
          status.walk_end = 1'b1;
        end else begin
          rd_en          = 1'b1;
          rd_addr        = rd_next;
          walk_addr_next = rd_next;
        end
      end
      CMD_LVL_END: begin
        if (kept_any) begin
          head_we = 1'b1;
          head_wd = first_kept;
          tail_we = 1'b1;
          tail_wd = last_kept;
        end else begin
          ne_clr = 1'b1;
        end
        if (!last_lvl) cur_lvl_next = cur_lvl + LW'(1);
      end
      CMD_DONE: begin
        emit      = 1'b1;
        emit_kind = KIND_QUEUED;
      end
      default: ;
    endcase

    if (ne_set) level_nonempty_next[la] = 1'b1;
    if (ne_clr) level_nonempty_next[la] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (req_we)   mem_req[mw_slot]   <= id_q;
    if (stamp_we) mem_stamp[mw_slot] <= now_q;
    if (lvl_we)   mem_lvl[mw_slot]   <= lvl_wd;
    if (nx_we)    mem_next[nx_addr]  <= nx_wd;
    if (rd_en) begin
      rd_req   <= mem_req[rd_addr];
      rd_stamp <= mem_stamp[rd_addr];
      rd_lvl   <= mem_lvl[rd_addr];
      rd_next  <= mem_next[rd_addr];
    end
    if (head_we) level_head[la] <= head_wd;
    if (tail_we) level_tail[la] <= tail_wd;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      op_q  <= operation;
      id_q  <= request_id;
      pri_q <= priority_req;
      now_q <= now_ms;
    end
    idx        <= idx_next;
    srch_slot  <= srch_slot_next;
    cur        <= cur_next_slot;
    cur_lvl    <= cur_lvl_next;
    rem_next   <= rem_next_next;
    cur_tail   <= cur_tail_next;
    walk_addr  <= walk_addr_next;
    first_kept <= first_kept_next;
    last_kept  <= last_kept_next;
    request_id_res <= emit_id;
    result_kind    <= emit_kind;
    last           <= emit_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid     <= '0;
      level_nonempty <= '0;
      queued_count   <= '0;
      pend           <= 1'b0;
      kept_any       <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      slot_valid     <= slot_valid_next;
      level_nonempty <= level_nonempty_next;
      queued_count   <= queued_count_next;
      pend           <= pend_next;
      kept_any       <= kept_any_next;
      result_valid   <= emit;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(queued_count) <= CAPACITY)
    else $error("queued count above capacity");

  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(cmd != CMD_IDLE))
    else $error("result while idle");

  a_walk_level: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_WALK) |-> level_nonempty[cur_lvl])
    else $error("walking an empty level");

  a_count_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_IDLE) |-> (int'(queued_count) == $countones(slot_valid)))
    else $error("count disagrees with valid slots");
`endif

endmodule
